### src/vbp_pkg.sv
package vbp_pkg;

    localparam int ADC_BITS     = 12;
    localparam int ADC_MAX_CODE = (1 << ADC_BITS) - 1;
    localparam int MV_BITS      = 15;
    localparam int MV_SCALE     = 19717;
    localparam int MV_CLAMP     = 20000;
    localparam int SCALE_BITS   = 15;
    localparam int PROD_BITS    = ADC_BITS + SCALE_BITS;

    localparam logic [MV_BITS-1:0] SAFE5V_RESET = MV_BITS'(4750);
    localparam logic [MV_BITS-1:0] SAFE0V_RESET = MV_BITS'(800);

    typedef enum logic [1:0] {
        PH_UNKNOWN   = 2'd0,
        PH_ABSENT    = 2'd1,
        PH_TRANSIENT = 2'd2,
        PH_PRESENT   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DETECTED = 2'd1,
        EV_REMOVED  = 2'd2
    } t_event;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_READ   = 1'b1
    } t_mode;

    typedef enum logic {
        CFG_SAFE5V_LOWER = 1'b0,
        CFG_SAFE0V_UPPER = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                mode;
        logic [ADC_BITS-1:0] adc_code;
    } t_vbp_in;

    typedef struct packed {
        logic [MV_BITS-1:0] vbus_mv;
        logic [1:0]         vbus_state;
        logic [1:0]         event_code;
        logic               watch_high;
        logic               transition_seen;
        logic               vbus_present;
    } t_vbp_out;

endpackage

### src/vbus_presence_tracker.sv
// VBUS presence tracker.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat is either an
// ADC sample (mode 0) or a read-and-clear of the 0V-to-5V transition flag
// (mode 1). Every input beat yields exactly one result beat on the output
// channel (o_out_valid / i_out_ready / o_out_data).
// The configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
// i_cfg_data) writes the vSafe5V lower and vSafe0V upper thresholds in mV;
// it is always ready. Write it only while no result is pending.
// The result is valid in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while each result is taken; scaling and the
// phase update are a single combinational pass into the output register, so
// the phase loop closes through the phase register alone.
// Reset: phase unknown, both marks clear, thresholds 4750 mV and 800 mV, no
// result pending.
// Stall: a result not taken holds in the output register; while it waits,
// a new beat is accepted only in the cycle the held result leaves.
module vbus_presence_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  vbp_pkg::t_vbp_in           i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output vbp_pkg::t_vbp_out          o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [vbp_pkg::MV_BITS-1:0] i_cfg_data
);
    import vbp_pkg::*;

    logic [MV_BITS-1:0] r_safe5v, r_safe0v;
    t_phase             r_phase, n_phase;
    logic               r_left_zero, n_left_zero;
    logic               r_rise, n_rise;
    logic               r_out_valid;
    t_vbp_out           r_out_data, n_out_data;

    logic [MV_BITS-1:0] mv;
    logic               accept;
    logic               is_read;
    logic               ge5, gt5, le0, lt0;
    t_event             ev;
    logic               high;

    vbp_scale u_scale (
        .i_code (i_in_data.adc_code),
        .o_mv   (mv)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign is_read     = (i_in_data.mode == MODE_READ);

    assign ge5 = (mv >= r_safe5v);
    assign gt5 = (mv >  r_safe5v);
    assign le0 = (mv <= r_safe0v);
    assign lt0 = (mv <  r_safe0v);

    // Next phase and marks.
    always_comb begin
        n_phase     = r_phase;
        n_left_zero = r_left_zero;
        n_rise      = r_rise;
        if (is_read) begin
            n_rise = 1'b0;
        end else begin
            case (r_phase)
                PH_UNKNOWN: begin
                    // first sample: strict classification, marks restart
                    n_left_zero = 1'b0;
                    n_rise      = 1'b0;
                    if (gt5) begin
                        n_phase = PH_PRESENT;
                    end else if (lt0) begin
                        n_phase = PH_ABSENT;
                    end else begin
                        n_phase = PH_TRANSIENT;
                        n_rise  = 1'b1;
                    end
                end
                PH_ABSENT: begin
                    if (le0) begin
                        n_phase = PH_ABSENT;
                    end else if (!ge5) begin
                        n_phase     = PH_TRANSIENT;
                        n_left_zero = 1'b1;
                        n_rise      = 1'b0;
                    end else begin
                        n_phase     = PH_PRESENT;
                        n_left_zero = 1'b0;
                        n_rise      = 1'b1;
                    end
                end
                PH_TRANSIENT: begin
                    if (ge5) begin
                        n_phase = PH_PRESENT;
                        if (r_left_zero) begin
                            n_left_zero = 1'b0;
                            n_rise      = 1'b1;
                        end
                    end else if (le0) begin
                        n_phase = PH_ABSENT;
                        if (!r_left_zero) begin
                            n_rise = 1'b0;
                        end
                    end
                end
                PH_PRESENT: begin
                    if (ge5) begin
                        n_phase = PH_PRESENT;
                    end else if (!le0) begin
                        n_phase = PH_TRANSIENT;
                    end else begin
                        n_phase = PH_ABSENT;
                        n_rise  = 1'b0;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Event and watchdog window for this beat.
    always_comb begin
        ev   = EV_NONE;
        high = 1'b0;
        if (!is_read) begin
            case (r_phase)
                PH_UNKNOWN: begin
                    high = 1'b0;
                end
                PH_ABSENT: begin
                    if (!le0 && ge5) begin
                        ev   = EV_DETECTED;
                        high = 1'b1;
                    end
                end
                PH_TRANSIENT: begin
                    if (ge5) begin
                        high = 1'b1;
                        if (r_left_zero) begin
                            ev = EV_DETECTED;
                        end
                    end else if (le0) begin
                        if (!r_left_zero) begin
                            ev = EV_REMOVED;
                        end
                    end else begin
                        high = !r_left_zero;
                    end
                end
                PH_PRESENT: begin
                    if (ge5 || !le0) begin
                        high = 1'b1;
                    end else begin
                        ev = EV_REMOVED;
                    end
                end
                default: begin
                    high = 1'b0;
                end
            endcase
        end
    end

    // Assemble the result beat.
    always_comb begin
        n_out_data.vbus_mv         = is_read ? '0 : mv;
        n_out_data.vbus_state      = n_phase;
        n_out_data.event_code      = ev;
        n_out_data.watch_high      = high;
        n_out_data.transition_seen = is_read && r_rise;
        n_out_data.vbus_present    = (n_phase == PH_PRESENT);
    end

    // Control state and thresholds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe5v    <= SAFE5V_RESET;
            r_safe0v    <= SAFE0V_RESET;
            r_phase     <= PH_UNKNOWN;
            r_left_zero <= 1'b0;
            r_rise      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SAFE5V_LOWER: r_safe5v <= i_cfg_data;
                    CFG_SAFE0V_UPPER: r_safe0v <= i_cfg_data;
                    default: begin
                        r_safe5v <= r_safe5v;
                    end
                endcase
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_left_zero <= n_left_zero;
                r_rise      <= n_rise;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                // drop the result once taken
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### src/vbp_scale.sv
module vbp_scale (
    input  logic [vbp_pkg::ADC_BITS-1:0] i_code,
    output logic [vbp_pkg::MV_BITS-1:0]  o_mv
);
    import vbp_pkg::*;

    localparam int SUM_BITS = PROD_BITS + 1;
    localparam int Q_BITS   = SUM_BITS - ADC_BITS;
    localparam int R_BITS   = ADC_BITS + 2;

    logic [PROD_BITS-1:0] prod;
    logic [SUM_BITS-1:0]  approx;
    logic [Q_BITS-1:0]    q_est;
    logic [R_BITS-1:0]    rem;
    logic [Q_BITS-1:0]    q_fix;

    // Divide by 2^n - 1 as x/2^n * (1 + 2^-n + 2^-2n); the estimate runs low
    // by at most one, which the remainder compares against one and two divisors fix.
    always_comb begin
        prod   = PROD_BITS'(i_code) * PROD_BITS'(MV_SCALE);
        approx = SUM_BITS'(prod) + SUM_BITS'(prod >> ADC_BITS)
               + SUM_BITS'(prod >> (2 * ADC_BITS));
        q_est  = Q_BITS'(approx >> ADC_BITS);
        // remainder modulo 2^R_BITS: x - q*2^n + q
        rem    = prod[R_BITS-1:0] - {q_est[1:0], {ADC_BITS{1'b0}}} + q_est[R_BITS-1:0];
        if (rem >= R_BITS'(2 * ADC_MAX_CODE)) begin
            q_fix = q_est + Q_BITS'(2);
        end else if (rem >= R_BITS'(ADC_MAX_CODE)) begin
            q_fix = q_est + Q_BITS'(1);
        end else begin
            q_fix = q_est;
        end
        if (q_fix > Q_BITS'(MV_CLAMP)) begin
            o_mv = MV_BITS'(MV_CLAMP);
        end else begin
            o_mv = q_fix[MV_BITS-1:0];
        end
    end

endmodule
